// File: design/lpb_pkg.sv
// Package for the layer pixel blend and composite pipeline.
// Holds blend mode codes, register indexes, the pipeline item type and the
// constant tables for soft light. Depends on nothing.
package lpb_pkg;

    // Blend mode codes
    localparam logic [3:0] MODE_NORMAL   = 4'd0;
    localparam logic [3:0] MODE_MULTIPLY = 4'd1;
    localparam logic [3:0] MODE_SCREEN   = 4'd2;
    localparam logic [3:0] MODE_OVERLAY  = 4'd3;
    localparam logic [3:0] MODE_DARKEN   = 4'd4;
    localparam logic [3:0] MODE_LIGHTEN  = 4'd5;
    localparam logic [3:0] MODE_DIFF     = 4'd6;
    localparam logic [3:0] MODE_ADD      = 4'd7;
    localparam logic [3:0] MODE_SOFT     = 4'd8;
    localparam logic [3:0] MODE_HARD     = 4'd9;

    // Configuration register indexes
    localparam logic [2:0] REG_BLEND_MODE    = 3'd0;
    localparam logic [2:0] REG_LAYER_OPACITY = 3'd1;
    localparam logic [2:0] REG_MASK_ENABLE   = 3'd2;
    localparam logic [2:0] REG_TOP_HAS_ALPHA = 3'd3;
    localparam logic [2:0] REG_LAYER_VISIBLE = 3'd4;

    // 255^3 and half of it, the denominator of the final lerp
    localparam logic [31:0] CUBE255      = 32'd16581375;
    localparam logic [31:0] HALF_CUBE255 = 32'd8290687;

    // Reciprocal of 255 scaled by 2^32, rounded down
    localparam logic [24:0] RECIP255 = 25'h1010101;

    // Color channels and lanes (three colors plus alpha)
    localparam int NCH   = 3;
    localparam int NLANE = 4;

    // Tables for soft light
    typedef logic [255:0][16:0] dtab_t;
    typedef logic [63:0][22:0]  ptab_t;
    typedef logic [255:0][13:0] qtab_t;

    // One item as it moves down the pipeline; each stage uses a subset.
    typedef struct packed {
        logic [NLANE-1:0][31:0] num;
        logic [NLANE-1:0][31:0] q0;
        logic [NLANE-1:0][1:0]  lvl;
        logic [NCH-1:0][7:0]    addb;
        logic [NLANE-1:0][7:0]  base;
        logic [NCH-1:0][7:0]    top;
        logic [7:0]             ta;
        logic [7:0]             mw;
        logic [23:0]            alpha;
    } lpb_item_t;

    // round(65536 * sqrt(v / 255)) in Q1.16
    function automatic logic [16:0] sqrt_q16(input int unsigned v);
        longint unsigned x;
        longint unsigned r;
        longint unsigned bv;
        x  = (longint'(v) << 34) / 255;
        r  = 0;
        bv = longint'(1) << 44;
        while (bv > x)
            bv = bv >> 2;
        while (bv != 0) begin
            if (x >= r + bv) begin
                x = x - (r + bv);
                r = (r >> 1) + bv;
            end else begin
                r = r >> 1;
            end
            bv = bv >> 2;
        end
        return 17'((r + 1) >> 1);
    endfunction

    // Soft light lift for bright base: sqrt term minus base in Q1.16, floored at zero
    function automatic dtab_t build_soft_d();
        dtab_t tab;
        longint unsigned sq;
        longint unsigned b16;
        for (int v = 0; v < 256; v++) begin
            sq  = longint'(sqrt_q16(v));
            b16 = (longint'(v) * 131072 + 255) / 510;
            tab[v] = (sq > b16) ? 17'(sq - b16) : 17'd0;
        end
        return tab;
    endfunction

    // Soft light lift for dark base: 16b^3 - 12b^2 + 3b scaled by 255^3
    function automatic ptab_t build_soft_p();
        ptab_t tab;
        longint unsigned b;
        for (int v = 0; v < 64; v++) begin
            b = longint'(v);
            tab[v] = 23'(16 * b * b * b + 195075 * b - 3060 * b * b);
        end
        return tab;
    endfunction

    // b * (255 - b)
    function automatic qtab_t build_soft_q();
        qtab_t tab;
        for (int v = 0; v < 256; v++)
            tab[v] = 14'(v * (255 - v));
        return tab;
    endfunction

endpackage

// File: design/layer_pixel_blend_composite_core.sv
// Top level of the layer pixel blend and composite pipeline.
// Uses lpb_pkg for mode codes, the item type and the soft light tables.
//
// Usage: an item on the input channel is one base pixel, one top pixel and
// one mask weight; it is taken at a clock edge with in_valid high and
// in_stall low. Each item gives exactly one composited pixel on the output
// channel, taken at an edge with out_valid high and out_stall low.
// The pipeline has 17 register stages, and one item enters per cycle
// while in_stall is low. The blend path
// uses three divide-by-255 levels, and the lerp three more; each level is a
// reciprocal multiply stage followed by a correction stage.
// Each stage holds its item until the next stage can take it, so bubbles
// close up while the output is stalled and in_stall only rises once every
// stage holds an item. Nothing is lost or repeated under stall.
// Configuration registers are written through cfg_wr_en, cfg_index and
// cfg_wdata; the user must do so only while the pipeline is empty, as the
// block does not enforce it. Reset clears all valid bits and loads the
// defaults: normal mode, full opacity, no mask, top alpha used, layer visible.
module layer_pixel_blend_composite_core
    import lpb_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_wr_en,
    input  logic [2:0] cfg_index,
    input  logic [7:0] cfg_wdata,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] base_red,
    input  logic [7:0] base_green,
    input  logic [7:0] base_blue,
    input  logic [7:0] base_alpha,
    input  logic [7:0] top_red,
    input  logic [7:0] top_green,
    input  logic [7:0] top_blue,
    input  logic [7:0] top_alpha,
    input  logic [7:0] mask_weight,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] out_red,
    output logic [7:0] out_green,
    output logic [7:0] out_blue,
    output logic [7:0] out_alpha
);

    localparam int NST = 17;

    localparam dtab_t SOFT_D = build_soft_d();
    localparam ptab_t SOFT_P = build_soft_p();
    localparam qtab_t SOFT_Q = build_soft_q();

    logic [3:0] blend_mode_reg;
    logic [7:0] layer_opacity_reg;
    logic       mask_enable_reg;
    logic       top_has_alpha_reg;
    logic       layer_visible_reg;

    logic [NST-1:0] valid_reg;
    logic [NST-1:0] ready;
    lpb_item_t      stage_reg  [NST];
    lpb_item_t      stage_next [NST];

    // Blend numerators: what to divide, how many times by 255, and what to add.
    function automatic lpb_item_t f_blend(input lpb_item_t d, input logic [3:0] mode,
                                          input logic [7:0] opacity);
        lpb_item_t  o;
        logic [7:0] b;
        logic [7:0] t;
        logic [7:0] k8;
        logic [31:0] bt;
        logic [31:0] inv;
        logic [31:0] lift;
        o = d;
        o.q0 = '0;
        o.alpha = 24'(16'(d.ta) * 16'(opacity));
        for (int c = 0; c < NCH; c++) begin
            b   = d.base[c];
            t   = d.top[c];
            k8  = {t[6:0], 1'b1};
            bt  = 32'(16'(b) * 16'(t));
            inv = 32'(16'(8'd255 - b) * 16'(8'd255 - t));
            o.addb[c] = 8'd0;
            o.lvl[c]  = 2'd0;
            o.num[c]  = 32'(t);
            unique case (mode)
                MODE_MULTIPLY: begin
                    o.num[c] = bt + 32'd127;
                    o.lvl[c] = 2'd1;
                end
                MODE_SCREEN: begin
                    o.num[c] = 32'd65025 - inv + 32'd127;
                    o.lvl[c] = 2'd1;
                end
                MODE_OVERLAY, MODE_HARD: begin
                    o.lvl[c] = 2'd1;
                    if (((mode == MODE_OVERLAY) && !b[7]) || ((mode == MODE_HARD) && !t[7]))
                        o.num[c] = (bt << 1) + 32'd127;
                    else
                        o.num[c] = 32'd65025 - (inv << 1) + 32'd127;
                end
                MODE_DARKEN:  o.num[c] = (b < t) ? 32'(b) : 32'(t);
                MODE_LIGHTEN: o.num[c] = (b > t) ? 32'(b) : 32'(t);
                MODE_DIFF:    o.num[c] = (b > t) ? 32'(b - t) : 32'(t - b);
                MODE_ADD:     o.num[c] = 32'(b) + 32'(t);
                MODE_SOFT: begin
                    if (!t[7]) begin
                        // Darkening half: b - (1-2t) b (1-b), rounded over 255^2
                        o.num[c] = 32'(b) * 32'd65025
                                 - 32'(8'd255 - {t[6:0], 1'b0}) * 32'(SOFT_Q[b])
                                 + 32'd32512;
                        o.lvl[c] = 2'd2;
                    end else if (b < 8'd64) begin
                        // Lightening half, dark base: exact polynomial over 255^3
                        o.num[c]  = 32'(k8) * 32'(SOFT_P[b[5:0]]) + HALF_CUBE255;
                        o.lvl[c]  = 2'd3;
                        o.addb[c] = b;
                    end else begin
                        // Lightening half, bright base: square root table in Q1.16
                        lift = (32'(b) << 16) + 32'(k8) * 32'(SOFT_D[b]) + 32'd32768;
                        o.num[c] = lift >> 16;
                    end
                end
                default: o.num[c] = 32'(t);
            endcase
        end
        o.lvl[NLANE-1] = 2'd0;
        o.num[NLANE-1] = '0;
        return o;
    endfunction

    // First half of a divide by 255: quotient estimate, low by at most one.
    function automatic lpb_item_t f_diva(input lpb_item_t d, input logic [1:0] level);
        lpb_item_t   o;
        logic [56:0] prod;
        o = d;
        for (int c = 0; c < NLANE; c++) begin
            prod = 57'(d.num[c]) * 57'(RECIP255);
            if (d.lvl[c] >= level)
                o.q0[c] = 32'(prod[56:32]);
        end
        return o;
    endfunction

    // Second half of a divide by 255: one compare and correct.
    function automatic lpb_item_t f_divb(input lpb_item_t d, input logic [1:0] level);
        lpb_item_t   o;
        logic [31:0] rem;
        o = d;
        for (int c = 0; c < NLANE; c++) begin
            rem = d.num[c] - d.q0[c] * 32'd255;
            if (d.lvl[c] >= level)
                o.num[c] = (rem >= 32'd255) ? d.q0[c] + 32'd1 : d.q0[c];
        end
        return o;
    endfunction

    // Add the base term and clamp each blended channel; alpha lane blends to full.
    function automatic lpb_item_t f_sat(input lpb_item_t d);
        lpb_item_t   o;
        logic [32:0] sum;
        o = d;
        for (int c = 0; c < NCH; c++) begin
            sum = 33'(d.num[c]) + 33'(d.addb[c]);
            o.num[c] = (sum > 33'd255) ? 32'd255 : 32'(sum[7:0]);
        end
        o.num[NLANE-1] = 32'd255;
        return o;
    endfunction

    // Lerp products: blended value times alpha, base times the rest.
    function automatic lpb_item_t f_prod(input lpb_item_t d);
        lpb_item_t o;
        o = d;
        for (int c = 0; c < NLANE; c++) begin
            o.num[c] = 32'(d.num[c][7:0]) * 32'(d.alpha);
            o.q0[c]  = 32'(d.base[c]) * (CUBE255 - 32'(d.alpha));
        end
        return o;
    endfunction

    // Lerp sum with rounding offset; every lane then divides three times.
    function automatic lpb_item_t f_sum(input lpb_item_t d);
        lpb_item_t o;
        o = d;
        for (int c = 0; c < NLANE; c++) begin
            o.num[c] = d.num[c] + d.q0[c] + HALF_CUBE255;
            o.lvl[c] = 2'd3;
        end
        return o;
    endfunction

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            blend_mode_reg    <= MODE_NORMAL;
            layer_opacity_reg <= 8'd255;
            mask_enable_reg   <= 1'b0;
            top_has_alpha_reg <= 1'b1;
            layer_visible_reg <= 1'b1;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_BLEND_MODE:    blend_mode_reg    <= cfg_wdata[3:0];
                REG_LAYER_OPACITY: layer_opacity_reg <= cfg_wdata;
                REG_MASK_ENABLE:   mask_enable_reg   <= cfg_wdata[0];
                REG_TOP_HAS_ALPHA: top_has_alpha_reg <= cfg_wdata[0];
                REG_LAYER_VISIBLE: layer_visible_reg <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // Stage hand-off: a stage can take an item when it is empty or its item moves on.
    always_comb
    begin
        ready[NST-1] = !valid_reg[NST-1] || !out_stall;
        for (int s = NST - 2; s >= 0; s--)
            ready[s] = !valid_reg[s] || ready[s+1];
    end

    assign in_stall = !ready[0];

    // Input stage: capture the pixel pair and the effective alpha and mask.
    always_comb
    begin
        stage_next[0]         = '0;
        stage_next[0].base[0] = base_red;
        stage_next[0].base[1] = base_green;
        stage_next[0].base[2] = base_blue;
        stage_next[0].base[3] = base_alpha;
        stage_next[0].top[0]  = top_red;
        stage_next[0].top[1]  = top_green;
        stage_next[0].top[2]  = top_blue;
        stage_next[0].ta      = top_has_alpha_reg ? top_alpha : 8'd255;
        stage_next[0].mw      = mask_enable_reg ? mask_weight : 8'd255;
    end

    // Work of each later stage
    for (genvar s = 1; s < NST; s++)
    begin : g_stage
        always_comb
        begin
            unique case (s)
                1: stage_next[s] = f_blend(stage_reg[s-1], blend_mode_reg, layer_opacity_reg);
                2:
                begin
                    stage_next[s] = f_diva(stage_reg[s-1], 2'd1);
                    stage_next[s].alpha = layer_visible_reg
                        ? 24'(stage_reg[s-1].alpha[15:0]) * 24'(stage_reg[s-1].mw) : 24'd0;
                end
                3, 12:  stage_next[s] = f_divb(stage_reg[s-1], 2'd1);
                4, 13:  stage_next[s] = f_diva(stage_reg[s-1], 2'd2);
                5, 14:  stage_next[s] = f_divb(stage_reg[s-1], 2'd2);
                6, 15:  stage_next[s] = f_diva(stage_reg[s-1], 2'd3);
                7, 16:  stage_next[s] = f_divb(stage_reg[s-1], 2'd3);
                8:      stage_next[s] = f_sat(stage_reg[s-1]);
                9:      stage_next[s] = f_prod(stage_reg[s-1]);
                10:     stage_next[s] = f_sum(stage_reg[s-1]);
                11:     stage_next[s] = f_diva(stage_reg[s-1], 2'd1);
                default: stage_next[s] = stage_reg[s-1];
            endcase
        end
    end

    // Valid bits travel with the items
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (ready[0])
                valid_reg[0] <= in_valid;
            for (int s = 1; s < NST; s++)
                if (ready[s])
                    valid_reg[s] <= valid_reg[s-1];
        end
    end

    // Pipeline payload registers
    always_ff @(posedge clk)
    begin
        for (int s = 0; s < NST; s++)
            if (ready[s])
                stage_reg[s] <= stage_next[s];
    end

    // Output channel
    assign out_valid = valid_reg[NST-1];
    assign out_red   = stage_reg[NST-1].num[0][7:0];
    assign out_green = stage_reg[NST-1].num[1][7:0];
    assign out_blue  = stage_reg[NST-1].num[2][7:0];
    assign out_alpha = stage_reg[NST-1].num[3][7:0];

endmodule

// File: dv/layer_pixel_blend_composite_core_tb.sv
// Testbench for the layer pixel blend and composite pipeline.
// Drives directed and random pixels under several register settings and checks
// every composited pixel against a predictor; depends on lpb_pkg and the core.
module layer_pixel_blend_composite_core_tb;
    import lpb_pkg::*;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
    } pixel_t;

    // Holds the expected composited pixels in order and counts mismatches.
    class composite_board;
        pixel_t pending[$];
        int errors;

        function void note_input(pixel_t px);
            pending.push_back(px);
        endfunction

        function void check_result(pixel_t got);
            pixel_t want;
            if (pending.size() == 0) begin
                $display("ERROR: unexpected pixel %h", got);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (got.red !== want.red) report_field("red", got.red, want.red);
            if (got.green !== want.green) report_field("green", got.green, want.green);
            if (got.blue !== want.blue) report_field("blue", got.blue, want.blue);
            if (got.alpha !== want.alpha) report_field("alpha", got.alpha, want.alpha);
        endfunction

        function void report_field(string name, logic [7:0] got, logic [7:0] want);
            if (errors < 40)
                $display("ERROR: %s got %0d want %0d at %0t", name, got, want, $realtime);
            errors++;
        endfunction
    endclass

    logic       clk;
    logic       rst_n;
    logic       cfg_wr_en;
    logic [2:0] cfg_index;
    logic [7:0] cfg_wdata;
    logic       in_valid;
    logic       in_stall;
    logic [7:0] base_red, base_green, base_blue, base_alpha;
    logic [7:0] top_red, top_green, top_blue, top_alpha, mask_weight;
    logic       out_valid;
    logic       out_stall;
    logic [7:0] out_red, out_green, out_blue, out_alpha;

    // Predictor copy of the registers.
    logic [3:0] mode_q;
    logic [7:0] opacity_q;
    logic       mask_en_q;
    logic       has_alpha_q;
    logic       visible_q;

    composite_board board;
    bit hold_off;
    int stall_pct;

    layer_pixel_blend_composite_core dut (.*);

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    // Run limit.
    initial
    begin
        #3000000;
        $display("layer_pixel_blend_composite_core_tb NOT OK");
        $finish;
    end

    function automatic longint unsigned int_sqrt(longint unsigned x);
        longint unsigned r;
        r = 0;
        while ((r + 1) * (r + 1) <= x)
            r++;
        return r;
    endfunction

    // Blended value of one channel under the current mode.
    function automatic int unsigned blend_value(int unsigned b, int unsigned t);
        longint unsigned x, p, sq, b16, diff;
        int unsigned r;
        case (mode_q)
            MODE_MULTIPLY: r = (b * t + 127) / 255;
            MODE_SCREEN:   r = (65025 - (255 - b) * (255 - t) + 127) / 255;
            MODE_OVERLAY, MODE_HARD:
            begin
                if ((mode_q == MODE_OVERLAY) ? (b <= 127) : (t <= 127))
                    r = (2 * b * t + 127) / 255;
                else
                    r = (65025 - 2 * (255 - b) * (255 - t) + 127) / 255;
            end
            MODE_DARKEN:   r = (b < t) ? b : t;
            MODE_LIGHTEN:  r = (b > t) ? b : t;
            MODE_DIFF:     r = (b > t) ? b - t : t - b;
            MODE_ADD:      r = b + t;
            MODE_SOFT:
            begin
                if (t <= 127) begin
                    x = longint'(b) * 65025 - longint'(255 - 2 * t) * b * (255 - b);
                    r = int'((x + 32512) / 65025);
                end else if (b <= 63) begin
                    p = 16 * longint'(b) * b * b + 195075 * longint'(b) - 3060 * longint'(b) * b;
                    x = longint'(b) * 16581375 + longint'(2 * t - 255) * p;
                    r = int'((x + 8290687) / 16581375);
                end else begin
                    sq = (int_sqrt((longint'(b) << 34) / 255) + 1) >> 1;
                    b16 = (longint'(b) * 131072 + 255) / 510;
                    diff = (sq > b16) ? sq - b16 : 0;
                    x = (longint'(b) << 16) + longint'(2 * t - 255) * diff + 32768;
                    r = int'(x >> 16);
                end
            end
            default:       r = t;
        endcase
        return (r > 255) ? 255 : r;
    endfunction

    function automatic pixel_t composite_pixel(pixel_t bp, pixel_t tp, logic [7:0] mw);
        longint unsigned a, ta, m;
        pixel_t res;
        ta = has_alpha_q ? tp.alpha : 255;
        m = mask_en_q ? mw : 255;
        a = ta * opacity_q * m;
        if (!visible_q || a == 0)
            return bp;
        res.red = 8'((blend_value(32'(bp.red), 32'(tp.red)) * a + bp.red * (16581375 - a)
            + 8290687) / 16581375);
        res.green = 8'((blend_value(32'(bp.green), 32'(tp.green)) * a
            + bp.green * (16581375 - a) + 8290687) / 16581375);
        res.blue = 8'((blend_value(32'(bp.blue), 32'(tp.blue)) * a + bp.blue * (16581375 - a)
            + 8290687) / 16581375);
        res.alpha = 8'((255 * a + bp.alpha * (16581375 - a) + 8290687) / 16581375);
        return res;
    endfunction

    // Output side: random stall pattern, long hold-off on request, checking.
    always @(posedge clk)
    begin
        if (rst_n) begin
            if (out_valid && !out_stall)
                board.check_result({out_red, out_green, out_blue, out_alpha});
            out_stall <= hold_off || ($urandom_range(99) < stall_pct);
        end
    end

    // Accepted items are predicted at the edge they are taken.
    always @(posedge clk)
    begin
        if (rst_n && in_valid && !in_stall)
            board.note_input(composite_pixel({base_red, base_green, base_blue, base_alpha},
                {top_red, top_green, top_blue, top_alpha}, mask_weight));
    end

    task automatic write_reg(logic [2:0] idx, logic [7:0] val);
        cfg_wr_en <= 1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_wr_en <= 0;
        case (idx)
            REG_BLEND_MODE:    mode_q = val[3:0];
            REG_LAYER_OPACITY: opacity_q = val;
            REG_MASK_ENABLE:   mask_en_q = val[0];
            REG_TOP_HAS_ALPHA: has_alpha_q = val[0];
            default:           visible_q = val[0];
        endcase
        @(posedge clk);
    endtask

    task automatic drain();
        while (board.pending.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    // Offers one item and waits until it is taken; valid stays high between items.
    task automatic send_pixel(logic [7:0] br, bg, bb, ba, tr, tg, tb, tval, mw);
        in_valid <= 1;
        base_red <= br; base_green <= bg; base_blue <= bb; base_alpha <= ba;
        top_red <= tr; top_green <= tg; top_blue <= tb; top_alpha <= tval;
        mask_weight <= mw;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    task automatic idle_gap(int n);
        in_valid <= 0;
        repeat (n) @(posedge clk);
    endtask

    task automatic send_random(int count);
        int left;
        left = count;
        while (left > 0) begin
            for (int k = $urandom_range(12, 1); k > 0 && left > 0; k--) begin
                send_pixel(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                    8'($urandom), 8'($urandom), 8'($urandom),
                    ($urandom_range(9) == 0) ? 8'd0 : 8'($urandom),
                    ($urandom_range(9) == 0) ? 8'd255 : 8'($urandom));
                left--;
            end
            if ($urandom_range(2) != 0)
                idle_gap($urandom_range(4, 1));
        end
        idle_gap(0);
    endtask

    initial
    begin
        logic [7:0] vals[6];
        board = new();
        hold_off = 0;
        stall_pct = 0;
        rst_n = 0;
        cfg_wr_en = 0; cfg_index = 0; cfg_wdata = 0;
        in_valid = 0; out_stall = 0;
        {base_red, base_green, base_blue, base_alpha} = '0;
        {top_red, top_green, top_blue, top_alpha, mask_weight} = '0;
        mode_q = MODE_NORMAL; opacity_q = 255; mask_en_q = 0;
        has_alpha_q = 1; visible_q = 1;
        repeat (2) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // Directed: every mode, extreme and threshold values, full then zero alpha.
        vals = '{8'd0, 8'd63, 8'd64, 8'd127, 8'd128, 8'd255};
        for (int md = 0; md <= 10; md++) begin
            write_reg(REG_BLEND_MODE, 8'(md));
            for (int k = 0; k < 6; k++)
                send_pixel(vals[k], vals[5 - k], vals[(k + 2) % 6], vals[k],
                    vals[(k + 3) % 6], vals[k], vals[5 - k], 8'd255, vals[k]);
            send_pixel(8'd255, 8'd0, 8'd200, 8'd10, 8'd0, 8'd255, 8'd100, 8'd0, 8'd255);
            idle_gap(0);
            drain();
        end

        // Random phases over register settings, extremes included.
        for (int ph = 0; ph < 12; ph++) begin
            write_reg(REG_BLEND_MODE, 8'((ph < 10) ? ph : $urandom_range(15)));
            write_reg(REG_LAYER_OPACITY, (ph % 4 == 0) ? 8'd255 : (ph % 4 == 1) ? 8'd0
                : 8'($urandom));
            write_reg(REG_MASK_ENABLE, 8'(ph % 2));
            write_reg(REG_TOP_HAS_ALPHA, 8'((ph % 3) != 0));
            write_reg(REG_LAYER_VISIBLE, 8'(ph != 5));
            stall_pct = (ph % 3 == 0) ? 0 : (ph % 3 == 1) ? 30 : 70;
            if (ph == 3) begin
                // Long receiver hold-off so the pipeline fills and stalls its input.
                fork
                    begin
                        hold_off = 1;
                        repeat (60) @(posedge clk);
                        hold_off = 0;
                    end
                    send_random(70);
                join
            end else begin
                send_random(70);
            end
            drain();
        end

        if (board.pending.size() != 0)
            board.errors++;
        if (board.errors == 0)
            $display("layer_pixel_blend_composite_core_tb OK");
        else
            $display("layer_pixel_blend_composite_core_tb NOT OK");
        $finish;
    end
endmodule

// File: filelist.f
design/lpb_pkg.sv
design/layer_pixel_blend_composite_core.sv
dv/layer_pixel_blend_composite_core_tb.sv
